/* rtl/fdp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types and constants of the four-column single precision dot product.
// ----------------------------------------------------------------------------
package fdp_pkg;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;
    localparam int COLS   = 4;
    localparam int IDX_W  = 13;
    localparam int QDEPTH = 2;

    localparam logic [IDX_W-1:0] MAX_LEN  = 13'd4096;
    localparam logic [31:0]      QNAN     = 32'h7FC0_0000;
    localparam logic [31:0]      FP_ONE   = 32'h3F80_0000;
    localparam logic [31:0]      FP_NEG0  = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] row_elem;
        logic [31:0] col0_elem;
        logic [31:0] col1_elem;
        logic [31:0] col2_elem;
        logic [31:0] col3_elem;
        logic [31:0] start0;
        logic [31:0] start1;
        logic [31:0] start2;
        logic [31:0] start3;
    } t_in_word;

    typedef struct packed {
        logic [31:0] sum0;
        logic [31:0] sum1;
        logic [31:0] sum2;
        logic [31:0] sum3;
    } t_out_word;

    // classified element as it travels from front to back
    typedef struct packed {
        logic [31:0]             row;
        logic [COLS-1:0][31:0]   col;
        logic [COLS-1:0][31:0]   start;
        logic [LANE_W-1:0]       lane;
        logic                    first;
        logic                    in_full;
        logic                    red_pre;
        logic                    red_post;
        logic                    last;
    } t_job;

endpackage : fdp_pkg
`default_nettype wire

/* rtl/fp32_four_column_dot_product.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fp32_four_column_dot_product
// Four-column binary32 dot product with eight lane accumulators per column.
// ----------------------------------------------------------------------------
// Push one word per element: a row element, four column elements and four
// starting sums (read on the first element only). Elements within complete
// groups of eight fold into lane (index mod 8) of each column by a fused
// multiply-add; after the last complete group each sum adds lanes 0 to 7 in
// order, and remaining tail elements add a rounded product with a rounded
// addition. The last element of a vector pops out as one word of four sums.
// All rounding is to nearest even, subnormals are kept and every NaN comes out
// as 0x7FC00000. The vector length register (default 1, 0 acts as 1, values
// above 4096 act as 4096) is written through the configuration channel; a
// write restarts the element count, so write it only while the block is idle.
// Timing: every element passes through one shared, multi-cycle FMA unit. An
// FMA with special operands finishes straight from idle; otherwise it steps
// through multiply, normalise, align, add, renormalise and round (a zero
// addend goes from multiply to renormalise), shifting one bit per normalising
// step; a fused add shifts its addend up by about forty bits. A lane element
// costs four FMAs, a tail element eight, and each reduction adds thirty-two,
// so throughput is set by that unit and its normalising shifters. A two-word
// queue parts the front from the back, and an output register holds a
// finished word while the next element is taken.
// ----------------------------------------------------------------------------
module fp32_four_column_dot_product (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire fdp_pkg::t_in_word   i_in_word,
    output logic                     empty,
    input  wire logic                pop,
    output fdp_pkg::t_out_word       o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [12:0]         i_cfg_data
);
    import fdp_pkg::*;

    t_job job_in, job_out;
    logic job_wr, job_rd, job_full, job_empty;

    // classify and count incoming words
    fdp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_job_wr    (job_wr),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    // hold classified elements so the front keeps taking words
    fdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_rd    (job_rd),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // drain elements through the shared FMA and present finished sums
    fdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_rd    (job_rd),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

endmodule : fp32_four_column_dot_product
`default_nettype wire

/* rtl/fdp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module fdp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire fdp_pkg::t_job i_data,
    output logic               o_full,
    input  wire logic          i_rd,
    output fdp_pkg::t_job      o_data,
    output logic               o_empty
);
    import fdp_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_job             r_mem [0:QDEPTH-1];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule : fdp_queue
`default_nettype wire

/* rtl/fdp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_front
// Accept elements, track the element index and classify each element.
// ----------------------------------------------------------------------------
module fdp_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire fdp_pkg::t_in_word  i_in_word,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [12:0]        i_cfg_data,
    output logic                    o_job_wr,
    output fdp_pkg::t_job           o_job,
    input  wire logic               i_job_full
);
    import fdp_pkg::*;

    logic [IDX_W-1:0] r_vl, r_k;
    logic [IDX_W-1:0] len, full_n;
    logic [IDX_W:0]   k_inc;
    logic             last;

    assign o_cfg_ready = 1'b1;
    assign full        = i_job_full;
    assign o_job_wr    = push && !i_job_full;

    always_comb begin
        len = r_vl;
        if (r_vl == '0) begin
            len = IDX_W'(1);
        end else if (r_vl > MAX_LEN) begin
            len = MAX_LEN;
        end
        full_n = {len[IDX_W-1:LANE_W], LANE_W'(0)};
        k_inc  = {1'b0, r_k} + 1'b1;
        last   = (k_inc >= {1'b0, len});
    end

    always_comb begin
        o_job.row      = i_in_word.row_elem;
        o_job.col      = {i_in_word.col3_elem, i_in_word.col2_elem,
                          i_in_word.col1_elem, i_in_word.col0_elem};
        o_job.start    = {i_in_word.start3, i_in_word.start2,
                          i_in_word.start1, i_in_word.start0};
        o_job.lane     = r_k[LANE_W-1:0];
        o_job.first    = (r_k == '0);
        o_job.in_full  = (r_k < full_n);
        o_job.red_pre  = (r_k == '0) && (full_n == '0);
        o_job.red_post = (r_k < full_n) && (k_inc == {1'b0, full_n});
        o_job.last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= IDX_W'(1);
            r_k  <= '0;
        end else if (i_cfg_valid) begin
            // a length write abandons any partial dot product
            r_vl <= i_cfg_data;
            r_k  <= '0;
        end else if (o_job_wr) begin
            r_k <= last ? '0 : k_inc[IDX_W-1:0];
        end
    end

endmodule : fdp_front
`default_nettype wire

/* rtl/fdp_fma.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_fma
// Multi-cycle binary32 fused multiply-add, a*b+c, one round to nearest even.
// ----------------------------------------------------------------------------
module fdp_fma (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic [31:0] i_c,
    output logic             o_done,
    output logic [31:0]      o_res
);
    import fdp_pkg::*;

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL   = 3'd1;
    localparam logic [2:0] F_NORM  = 3'd2;
    localparam logic [2:0] F_ALIGN = 3'd3;
    localparam logic [2:0] F_ADD   = 3'd4;
    localparam logic [2:0] F_RNORM = 3'd5;
    localparam logic [2:0] F_ROUND = 3'd6;

    logic [2:0]         r_st;
    logic               r_done;
    logic [31:0]        r_res;
    logic               r_ps, r_cs, r_cz, r_sx, r_sy, r_s;
    logic [23:0]        r_ma, r_mb;
    logic signed [11:0] r_ea, r_eb, r_pe, r_ec, r_ex, r_e;
    logic [63:0]        r_pm, r_mc, r_mx, r_my, r_m;
    logic [47:0]        mul_p;

    // classification of the operands
    logic               a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_z, b_z, c_z;
    logic               ps, cs, spec;
    logic [31:0]        spec_res;
    logic [23:0]        ua, ub, uc;
    logic signed [11:0] uea, ueb, uec;

    function automatic logic [23:0] unp_m(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    endfunction

    function automatic logic signed [11:0] unp_e(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, x[30:23]}) - 12'sd150;
    endfunction

    always_comb begin
        a_nan = (&i_a[30:23]) && (|i_a[22:0]);
        b_nan = (&i_b[30:23]) && (|i_b[22:0]);
        c_nan = (&i_c[30:23]) && (|i_c[22:0]);
        a_inf = (&i_a[30:23]) && !(|i_a[22:0]);
        b_inf = (&i_b[30:23]) && !(|i_b[22:0]);
        c_inf = (&i_c[30:23]) && !(|i_c[22:0]);
        a_z   = !(|i_a[30:0]);
        b_z   = !(|i_b[30:0]);
        c_z   = !(|i_c[30:0]);
        ps    = i_a[31] ^ i_b[31];
        cs    = i_c[31];
        spec     = 1'b1;
        spec_res = QNAN;
        if (a_nan || b_nan || c_nan) begin
            spec_res = QNAN;
        end else if ((a_inf && b_z) || (b_inf && a_z)) begin
            spec_res = QNAN;
        end else if (a_inf || b_inf) begin
            spec_res = (c_inf && (cs != ps)) ? QNAN : {ps, 8'hFF, 23'd0};
        end else if (c_inf) begin
            spec_res = i_c;
        end else if (a_z || b_z) begin
            if (c_z) begin
                spec_res = (ps == cs) ? {ps, 31'd0} : 32'd0;
            end else begin
                spec_res = i_c;
            end
        end else begin
            spec = 1'b0;
        end
        ua  = unp_m(i_a);
        ub  = unp_m(i_b);
        uc  = unp_m(i_c);
        uea = unp_e(i_a);
        ueb = unp_e(i_b);
        uec = unp_e(i_c);
    end

    // full-width significand product
    assign mul_p = r_ma * r_mb;

    // alignment of the smaller addend with a sticky bit
    logic [63:0]        al_x, al_y, al_sh, al_mask;
    logic signed [11:0] al_ex, al_ey, al_d;
    logic               al_sx, al_sy;

    always_comb begin
        if (r_pe >= r_ec) begin
            al_x = r_pm; al_ex = r_pe; al_sx = r_ps;
            al_y = r_mc; al_ey = r_ec; al_sy = r_cs;
        end else begin
            al_x = r_mc; al_ex = r_ec; al_sx = r_cs;
            al_y = r_pm; al_ey = r_pe; al_sy = r_ps;
        end
        al_d    = al_ex - al_ey;
        al_mask = (64'd1 << al_d[5:0]) - 64'd1;
        al_sh   = al_y;
        if (al_d >= 12'sd63) begin
            al_sh = 64'd1;
        end else if (al_d > 12'sd0) begin
            al_sh = (al_y >> al_d[5:0]) | {63'd0, |(al_y & al_mask)};
        end
    end

    // signed add of the aligned pair
    logic [63:0] ad_r;
    logic        ad_s;

    always_comb begin
        if (r_sx == r_sy) begin
            ad_r = r_mx + r_my;
            ad_s = r_sx;
        end else if (r_mx >= r_my) begin
            ad_r = r_mx - r_my;
            ad_s = r_sx;
        end else begin
            ad_r = r_my - r_mx;
            ad_s = r_sy;
        end
    end

    // final rounding of a normalised 64-bit significand
    logic signed [11:0] rd_be, rd_sh;
    logic [63:0]        rd_rem, rd_half;
    logic [24:0]        rd_q;
    logic [31:0]        rd_bits, rd_res;

    always_comb begin
        rd_be   = r_e + 12'sd190;
        rd_sh   = (rd_be >= 12'sd1) ? 12'sd40 : 12'sd41 - rd_be;
        rd_rem  = r_m & ((64'd1 << rd_sh[5:0]) - 64'd1);
        rd_half = 64'd1 << (rd_sh[5:0] - 6'd1);
        rd_q    = '0;
        if (rd_sh > 12'sd64) begin
            rd_q = '0;
        end else if (rd_sh == 12'sd64) begin
            rd_q = {24'd0, (r_m > 64'h8000_0000_0000_0000)};
        end else begin
            rd_q = 25'(r_m >> rd_sh[5:0]);
            if ((rd_rem > rd_half) || ((rd_rem == rd_half) && rd_q[0])) begin
                rd_q = rd_q + 25'd1;
            end
        end
        rd_bits = ((rd_be >= 12'sd1) ? {1'b0, 8'(rd_be - 12'sd1), 23'd0} : 32'd0)
                  + {7'd0, rd_q};
        if (rd_bits >= 32'h7F80_0000) begin
            rd_bits = 32'h7F80_0000;
        end
        if (rd_be >= 12'sd255) begin
            rd_res = {r_s, 8'hFF, 23'd0};
        end else if (rd_be < -12'sd40) begin
            rd_res = {r_s, 31'd0};
        end else begin
            rd_res = {r_s, rd_bits[30:0]};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        case (r_st)
            F_IDLE: begin
                r_ps <= ps;   r_cs <= cs;  r_cz <= c_z;
                r_ma <= ua;   r_mb <= ub;  r_ea <= uea; r_eb <= ueb;
                r_mc <= {40'd0, uc};
                r_ec <= uec;
                if (spec) begin
                    r_res <= spec_res;
                end
            end
            F_MUL: begin
                r_pm <= {16'd0, mul_p};
                r_pe <= r_ea + r_eb;
                r_m  <= {16'd0, mul_p};
                r_e  <= r_ea + r_eb;
                r_s  <= r_ps;
            end
            F_NORM: begin
                if (!r_pm[62]) begin
                    r_pm <= r_pm << 1;
                    r_pe <= r_pe - 12'sd1;
                end
                if (!r_mc[62]) begin
                    r_mc <= r_mc << 1;
                    r_ec <= r_ec - 12'sd1;
                end
            end
            F_ALIGN: begin
                r_mx <= al_x;  r_my <= al_sh; r_ex <= al_ex;
                r_sx <= al_sx; r_sy <= al_sy;
            end
            F_ADD: begin
                r_m <= ad_r; r_e <= r_ex; r_s <= ad_s;
                if (ad_r == '0) begin
                    r_res <= 32'd0;
                end
            end
            F_RNORM: begin
                if (!r_m[63]) begin
                    r_m <= r_m << 1;
                    r_e <= r_e - 12'sd1;
                end
            end
            F_ROUND: begin
                r_res <= rd_res;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= F_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                F_IDLE: begin
                    if (i_start) begin
                        if (spec) begin
                            r_done <= 1'b1;
                        end else begin
                            r_st <= F_MUL;
                        end
                    end
                end
                F_MUL: begin
                    r_st <= r_cz ? F_RNORM : F_NORM;
                end
                F_NORM: begin
                    if (r_pm[62] && r_mc[62]) begin
                        r_st <= F_ALIGN;
                    end
                end
                F_ALIGN: begin
                    r_st <= F_ADD;
                end
                F_ADD: begin
                    if (ad_r == '0) begin
                        r_done <= 1'b1;
                        r_st   <= F_IDLE;
                    end else begin
                        r_st <= F_RNORM;
                    end
                end
                F_RNORM: begin
                    if (r_m[63]) begin
                        r_st <= F_ROUND;
                    end
                end
                F_ROUND: begin
                    r_done <= 1'b1;
                    r_st   <= F_IDLE;
                end
                default: begin
                    r_st <= F_IDLE;
                end
            endcase
        end
    end

endmodule : fdp_fma
`default_nettype wire

/* rtl/fdp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_back
// Sequence lane updates, reductions and tail terms through the shared FMA.
// ----------------------------------------------------------------------------
module fdp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fdp_pkg::t_job      i_job,
    input  wire logic               i_job_empty,
    output logic                    o_job_rd,
    output logic                    empty,
    input  wire logic               pop,
    output fdp_pkg::t_out_word      o_out_word
);
    import fdp_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RED  = 3'd1;
    localparam logic [2:0] B_LFMA = 3'd2;
    localparam logic [2:0] B_TMUL = 3'd3;
    localparam logic [2:0] B_TADD = 3'd4;
    localparam logic [2:0] B_FIN  = 3'd5;

    localparam int AW = $clog2(COLS * LANES);

    logic [2:0]              r_st;
    logic                    r_wait;
    t_job                    r_job;
    logic [1:0]              r_j;
    logic [LANE_W-1:0]       r_l;
    logic [31:0]             r_acc [0:COLS*LANES-1];
    logic [COLS*LANES-1:0]   r_accv;
    logic [COLS-1:0][31:0]   r_sum;
    logic [31:0]             r_prod;
    t_out_word               r_out;
    logic                    r_out_v;

    logic [AW-1:0]           acc_idx;
    logic [31:0]             acc_val, fa, fb, fc, f_res;
    logic                    f_start, f_done, op_st, out_take;

    assign op_st    = (r_st == B_RED) || (r_st == B_LFMA) ||
                      (r_st == B_TMUL) || (r_st == B_TADD);
    assign f_start  = op_st && !r_wait;
    assign acc_idx  = (r_st == B_RED) ? {r_j, r_l} : {r_j, r_job.lane};
    assign acc_val  = r_accv[acc_idx] ? r_acc[acc_idx] : 32'd0;
    assign o_job_rd = (r_st == B_IDLE) && !i_job_empty;
    assign out_take = (r_st == B_FIN) && r_job.last && (!r_out_v || pop);
    assign empty      = !r_out_v;
    assign o_out_word = r_out;

    always_comb begin
        fa = r_job.row;
        fb = r_job.col[r_j];
        fc = acc_val;
        case (r_st)
            B_RED: begin
                fa = r_sum[r_j]; fb = FP_ONE; fc = acc_val;
            end
            B_TMUL: begin
                fc = FP_NEG0;
            end
            B_TADD: begin
                fa = r_sum[r_j]; fb = FP_ONE; fc = r_prod;
            end
            default: begin
            end
        endcase
    end

    fdp_fma u_fma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (f_start),
        .i_a     (fa),
        .i_b     (fb),
        .i_c     (fc),
        .o_done  (f_done),
        .o_res   (f_res)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_job_rd) begin
            r_job <= i_job;
            if (i_job.first) begin
                r_sum <= i_job.start;
            end
        end
        if (f_done) begin
            case (r_st)
                B_RED:   r_sum[r_j] <= f_res;
                B_LFMA:  r_acc[acc_idx] <= f_res;
                B_TMUL:  r_prod <= f_res;
                B_TADD:  r_sum[r_j] <= f_res;
                default: begin
                end
            endcase
        end
        if (out_take) begin
            r_out <= {r_sum[0], r_sum[1], r_sum[2], r_sum[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_IDLE;
            r_wait  <= 1'b0;
            r_j     <= '0;
            r_l     <= '0;
            r_accv  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_v <= 1'b1;
            end else if (pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
            if (f_start) begin
                r_wait <= 1'b1;
            end else if (f_done) begin
                r_wait <= 1'b0;
            end
            case (r_st)
                B_IDLE: begin
                    if (o_job_rd) begin
                        if (i_job.first) begin
                            // lanes read as +0 until written again
                            r_accv <= '0;
                        end
                        r_j <= '0;
                        r_l <= '0;
                        if (i_job.red_pre) begin
                            r_st <= B_RED;
                        end else if (i_job.in_full) begin
                            r_st <= B_LFMA;
                        end else begin
                            r_st <= B_TMUL;
                        end
                    end
                end
                B_RED: begin
                    if (f_done) begin
                        r_l <= r_l + 1'b1;
                        if (r_l == LANE_W'(LANES-1)) begin
                            r_j <= r_j + 1'b1;
                            if (r_j == 2'(COLS-1)) begin
                                r_st <= r_job.in_full ? B_FIN : B_TMUL;
                            end
                        end
                    end
                end
                B_LFMA: begin
                    if (f_done) begin
                        r_accv[acc_idx] <= 1'b1;
                        r_j <= r_j + 1'b1;
                        if (r_j == 2'(COLS-1)) begin
                            r_l  <= '0;
                            r_st <= r_job.red_post ? B_RED : B_FIN;
                        end
                    end
                end
                B_TMUL: begin
                    if (f_done) begin
                        r_st <= B_TADD;
                    end
                end
                B_TADD: begin
                    if (f_done) begin
                        r_j  <= r_j + 1'b1;
                        r_st <= (r_j == 2'(COLS-1)) ? B_FIN : B_TMUL;
                    end
                end
                B_FIN: begin
                    if (!r_job.last || out_take) begin
                        r_st <= B_IDLE;
                    end
                end
                default: begin
                    r_st <= B_IDLE;
                end
            endcase
        end
    end

endmodule : fdp_back
`default_nettype wire
